[hw/rtl/bank_tag_slot_cache_unit_assert.svh]
// assertion macros used by the slot cache top module
`ifndef BANK_TAG_SLOT_CACHE_UNIT_ASSERT_SVH
`define BANK_TAG_SLOT_CACHE_UNIT_ASSERT_SVH

// same-cycle implication
`define BTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bts_pkg.sv]
// ----------------------------------------------------------------------------
// bts_pkg
// types and constants of the bank-tagged slot cache
// ----------------------------------------------------------------------------
package bts_pkg;

	localparam int ADDR_W    = 16;
	localparam int BANK_W    = 9;
	localparam int AGE_W     = 32;
	localparam int SLOT_W    = 3;
	localparam int SLOTS_DEF = 8;

	localparam logic [ADDR_W-1:0] LOW_REGION  = 16'h4000;
	localparam logic [ADDR_W-1:0] ADDR_RESET  = '1;
	localparam logic [BANK_W-1:0] BANK_RESET  = '0;
	localparam logic [AGE_W-1:0]  AGE_RESET   = '0;
	localparam logic [AGE_W-1:0]  COUNT_RESET = 32'd1;

	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_ALLOC  = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [ADDR_W-1:0] address;
		logic [BANK_W-1:0] bank;
	} req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot_index;
		logic              is_new;
	} rsp_t;

	// query token walking the cell row
	typedef struct packed {
		logic              valid;
		logic              cmd;
		logic [ADDR_W-1:0] address;
		logic [BANK_W-1:0] bank;
		logic              hit;
		logic [AGE_W-1:0]  best;
	} tok_t;

	// allocation write broadcast to all cells
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] address;
		logic [BANK_W-1:0] bank;
		logic [AGE_W-1:0]  age;
	} wr_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

endpackage

[hw/rtl/bts_cell.sv]
// ----------------------------------------------------------------------------
// bts_cell
// one slot of the table: holds its tags and age, compares the passing token
// ----------------------------------------------------------------------------
module bts_cell #(
	parameter int IW       = 3,
	parameter int CELL_IDX = 0
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bts_pkg::tok_t             tok_in,
	input  logic [IW-1:0]             hit_idx_in,
	input  logic [IW-1:0]             vic_in,
	input  bts_pkg::wr_t              wr,
	input  logic [IW-1:0]             wr_idx,
	input  logic [bts_pkg::AGE_W-1:0] age_counter,
	output bts_pkg::tok_t             tok_out,
	output logic [IW-1:0]             hit_idx_out,
	output logic [IW-1:0]             vic_out
);

	localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

	logic [bts_pkg::ADDR_W-1:0] tag_address_q;
	logic [bts_pkg::BANK_W-1:0] tag_bank_q;
	logic [bts_pkg::AGE_W-1:0]  slot_age_q;

	bts_pkg::tok_t              tok_d;
	bts_pkg::tok_t              tok_q;
	logic [IW-1:0]              hit_idx_d;
	logic [IW-1:0]              hit_idx_q;
	logic [IW-1:0]              vic_d;
	logic [IW-1:0]              vic_q;
	logic                       match;
	logic [bts_pkg::AGE_W-1:0]  age_gap;

	always_comb begin
		match     = (tag_address_q == tok_in.address) && (tag_bank_q == tok_in.bank);
		age_gap   = age_counter - slot_age_q;
		tok_d     = tok_in;
		hit_idx_d = hit_idx_in;
		vic_d     = vic_in;
		if (!tok_in.hit) begin
			if (match) begin
				tok_d.hit = 1'b1;
				hit_idx_d = MY_IDX;
			end else if ((tok_in.cmd == bts_pkg::CMD_ALLOC) && (age_gap > tok_in.best)) begin
				tok_d.best = age_gap;
				vic_d      = MY_IDX;
			end
		end
	end

	// slot storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_address_q <= bts_pkg::ADDR_RESET;
			tag_bank_q    <= bts_pkg::BANK_RESET;
			slot_age_q    <= bts_pkg::AGE_RESET;
		end else if (wr.en && (wr_idx == MY_IDX)) begin
			tag_address_q <= wr.address;
			tag_bank_q    <= wr.bank;
			slot_age_q    <= wr.age;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q     <= '0;
			hit_idx_q <= '0;
			vic_q     <= '0;
		end else begin
			tok_q     <= tok_d;
			hit_idx_q <= hit_idx_d;
			vic_q     <= vic_d;
		end
	end

	assign tok_out     = tok_q;
	assign hit_idx_out = hit_idx_q;
	assign vic_out     = vic_q;

endmodule

[hw/rtl/bank_tag_slot_cache_unit.sv]
// ----------------------------------------------------------------------------
// bank_tag_slot_cache_unit
// fully associative (address, bank) slot cache with age-based allocation
// ----------------------------------------------------------------------------
// A request walks a row of SLOTS cells, one slot per cycle, collecting the
// first tag match and the oldest slot by modular age distance. The request
// is registered as the query token, the token passes through the cell row,
// an allocation then writes the victim slot while the response is staged,
// and the staged response moves into the output register once that register
// is empty or its response is being taken. One request is in flight at a
// time; the next is accepted once the staged response has moved to the
// output register, even while that register still waits on rsp_stall.
// Addresses below 0x4000 are looked up with bank 0.
module bank_tag_slot_cache_unit #(
	parameter int SLOTS = bts_pkg::SLOTS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bts_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bts_pkg::rsp_t rsp
);

	`include "bank_tag_slot_cache_unit_assert.svh"

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	bts_pkg::state_t            state_q;
	bts_pkg::state_t            state_d;
	bts_pkg::tok_t              tok_q;
	bts_pkg::tok_t              chain [SLOTS+1];
	logic [IW-1:0]              hit_c [SLOTS+1];
	logic [IW-1:0]              vic_c [SLOTS+1];
	logic [SLOTS:0]             tok_valid_vec;
	bts_pkg::wr_t               wr;
	logic [IW-1:0]              wr_idx;
	logic [bts_pkg::AGE_W-1:0]  age_counter_q;
	bts_pkg::rsp_t              pend_d;
	bts_pkg::rsp_t              pend_q;
	bts_pkg::rsp_t              rsp_q;
	logic                       rsp_valid_q;
	logic                       accept;
	logic                       fin;
	logic                       move;
	logic                       rsp_take;

	assign accept   = req_valid && !req_stall;
	assign fin      = chain[SLOTS].valid;
	assign rsp_take = rsp_valid_q && !rsp_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bts_pkg::ST_IDLE: if (req_valid) state_d = bts_pkg::ST_SCAN;
			bts_pkg::ST_SCAN: if (fin) state_d = bts_pkg::ST_DONE;
			bts_pkg::ST_DONE: if (!rsp_valid_q || !rsp_stall) state_d = bts_pkg::ST_IDLE;
			default:          state_d = bts_pkg::ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		req_stall = 1'b1;
		move      = 1'b0;
		case (state_q)
			bts_pkg::ST_IDLE: req_stall = 1'b0;
			bts_pkg::ST_SCAN: req_stall = 1'b1;
			bts_pkg::ST_DONE: move      = !rsp_valid_q || !rsp_stall;
			default:          req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// query token injection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= accept;
			if (accept) begin
				tok_q.cmd     <= req.cmd;
				tok_q.address <= req.address;
				tok_q.bank    <= (req.address < bts_pkg::LOW_REGION) ? '0 : req.bank;
				tok_q.hit     <= 1'b0;
				tok_q.best    <= '0;
			end
		end
	end

	assign chain[0] = tok_q;
	assign hit_c[0] = '0;
	assign vic_c[0] = '0;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		bts_cell #(
			.IW       (IW),
			.CELL_IDX (i)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.tok_in      (chain[i]),
			.hit_idx_in  (hit_c[i]),
			.vic_in      (vic_c[i]),
			.wr          (wr),
			.wr_idx      (wr_idx),
			.age_counter (age_counter_q),
			.tok_out     (chain[i+1]),
			.hit_idx_out (hit_c[i+1]),
			.vic_out     (vic_c[i+1])
		);
	end

	for (genvar i = 0; i <= SLOTS; i++) begin : g_vld
		assign tok_valid_vec[i] = chain[i].valid;
	end

	// allocation write and response staging
	always_comb begin
		wr.en      = fin && (chain[SLOTS].cmd == bts_pkg::CMD_ALLOC) && !chain[SLOTS].hit;
		wr.address = chain[SLOTS].address;
		wr.bank    = chain[SLOTS].bank;
		wr.age     = age_counter_q;
		wr_idx     = vic_c[SLOTS];

		pend_d.found      = chain[SLOTS].hit || (chain[SLOTS].cmd == bts_pkg::CMD_ALLOC);
		pend_d.is_new     = !chain[SLOTS].hit && (chain[SLOTS].cmd == bts_pkg::CMD_ALLOC);
		pend_d.slot_index = '0;
		if (chain[SLOTS].hit) begin
			pend_d.slot_index = bts_pkg::SLOT_W'(hit_c[SLOTS]);
		end else if (chain[SLOTS].cmd == bts_pkg::CMD_ALLOC) begin
			pend_d.slot_index = bts_pkg::SLOT_W'(vic_c[SLOTS]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_counter_q <= bts_pkg::COUNT_RESET;
		end else if (wr.en) begin
			age_counter_q <= age_counter_q + 32'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			pend_q <= pend_d;
		end
		if (move) begin
			rsp_q <= pend_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (move) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_take) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`BTS_ASSERT_NOW(a_fin_in_scan, fin, state_q == bts_pkg::ST_SCAN, "token left row outside scan")
	`BTS_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_valid_vec), "more than one query token")
	`BTS_ASSERT_NEXT(a_count_step, wr.en, age_counter_q == $past(age_counter_q) + 32'd1, "no step")
	`BTS_ASSERT_NOW(a_new_found, rsp_valid_q && rsp_q.is_new, rsp_q.found, "new slot without found")

endmodule

[bench/bank_tag_slot_cache_unit_test.sv]
// ----------------------------------------------------------------------------
// bank_tag_slot_cache_unit_test
// self-checking bench for the bank-tagged slot cache
// ----------------------------------------------------------------------------
// A table of directed requests runs first: reset tags, misses, bank forcing
// below 0x4000 and the first allocations, with responses typed in where they
// are obvious. Random requests follow, mostly over a small key pool, so that
// hits, evictions and misses all occur. Each response is checked in order
// against its typed-in value or a local model of tag table, age stamps and
// age counter. Both sides idle at random, the output side holds off once for
// a long stretch, and the input side drains the block once before going on.
module bank_tag_slot_cache_unit_test;

	localparam int NSLOTS      = bts_pkg::SLOTS_DEF;
	localparam int N_RANDOM    = 650;
	localparam int N_DIRECTED  = 23;
	localparam int N_KEYS      = 12;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		bts_pkg::req_t stim;
		bit            fixed;
		bts_pkg::rsp_t known;
	} dir_row_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_stall;
	bts_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_stall;
	bts_pkg::rsp_t rsp;

	// model of the slot table
	logic [bts_pkg::ADDR_W-1:0] slot_addr_m [NSLOTS];
	logic [bts_pkg::BANK_W-1:0] slot_bank_m [NSLOTS];
	logic [bts_pkg::AGE_W-1:0]  slot_age_m  [NSLOTS];
	logic [bts_pkg::AGE_W-1:0]  age_count_m;

	bts_pkg::rsp_t              pending_rsp_q [$];
	logic [bts_pkg::ADDR_W-1:0] key_addr [N_KEYS];
	logic [bts_pkg::BANK_W-1:0] key_bank [N_KEYS];
	dir_row_t                   dir_tab [N_DIRECTED];

	int n_err;
	int n_sent;
	int n_hit_seen;
	int n_alloc_seen;
	int n_miss_seen;
	int cycle_count;
	int hold_left;
	bit hold_done;

	bank_tag_slot_cache_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic bit quiet_window();
		return (n_sent >= 300) && (n_sent < 420);
	endfunction

	// advance the model by one request and return its response
	function automatic bts_pkg::rsp_t slot_cache_access(bts_pkg::req_t r);
		logic [bts_pkg::BANK_W-1:0] bnk;
		logic [bts_pkg::AGE_W-1:0]  age_gap;
		logic [bts_pkg::AGE_W-1:0]  best;
		int                         victim;
		bts_pkg::rsp_t              res;
		bnk    = (r.address < bts_pkg::LOW_REGION) ? bts_pkg::BANK_RESET : r.bank;
		best   = '0;
		victim = 0;
		res    = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			if (slot_addr_m[i] == r.address && slot_bank_m[i] == bnk) begin
				res.found      = 1'b1;
				res.slot_index = bts_pkg::SLOT_W'(i);
				return res;
			end
			if (r.cmd == bts_pkg::CMD_ALLOC) begin
				age_gap = age_count_m - slot_age_m[i];
				if (age_gap > best) begin
					best   = age_gap;
					victim = i;
				end
			end
		end
		if (r.cmd == bts_pkg::CMD_LOOKUP)
			return res;
		slot_addr_m[victim] = r.address;
		slot_bank_m[victim] = bnk;
		slot_age_m[victim]  = age_count_m;
		age_count_m         = age_count_m + 32'd1;
		res.found      = 1'b1;
		res.slot_index = bts_pkg::SLOT_W'(victim);
		res.is_new     = 1'b1;
		return res;
	endfunction

	function automatic bts_pkg::req_t random_request();
		bts_pkg::req_t r;
		int            sel;
		int            k;
		sel   = $urandom_range(0, 99);
		r.cmd = ($urandom_range(0, 99) < 60) ? bts_pkg::CMD_ALLOC : bts_pkg::CMD_LOOKUP;
		if (sel < 60) begin
			k         = $urandom_range(0, N_KEYS - 1);
			r.address = key_addr[k];
			r.bank    = key_bank[k];
			if (r.address < bts_pkg::LOW_REGION && $urandom_range(0, 1) == 1)
				r.bank = bts_pkg::BANK_W'($urandom_range(0, 511));
		end else if (sel < 75) begin
			r.address = bts_pkg::ADDR_W'($urandom_range(16'h3FF0, 16'h400F));
			r.bank    = bts_pkg::BANK_W'($urandom_range(0, 511));
		end else begin
			r.address = bts_pkg::ADDR_W'($urandom_range(0, 65535));
			r.bank    = bts_pkg::BANK_W'($urandom_range(0, 511));
		end
		return r;
	endfunction

	task automatic send_request(input bts_pkg::req_t r, input bit fixed,
		input bts_pkg::rsp_t known);
		logic [31:0]   junk;
		bts_pkg::rsp_t want;
		@(negedge clk);
		while (!quiet_window() && $urandom_range(0, 99) < 27) begin
			junk      = $urandom;
			req_valid = 1'b0;
			req       = junk[$bits(bts_pkg::req_t)-1:0];
			@(negedge clk);
		end
		req_valid = 1'b1;
		req       = r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		want = slot_cache_access(r);
		if (fixed)
			want = known;
		pending_rsp_q.push_back(want);
		n_sent++;
	endtask

	// response side
	initial begin
		rsp_stall = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && n_sent >= 120) begin
				hold_done = 1'b1;
				hold_left = 80;
			end
			if (hold_left > 0) begin
				rsp_stall = 1'b1;
				hold_left--;
			end else if (quiet_window()) begin
				rsp_stall = 1'b0;
			end else begin
				rsp_stall = ($urandom_range(0, 99) < 27);
			end
		end
	end

	always @(posedge clk) begin
		bts_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp_q.size() == 0) begin
				n_err++;
				$display("%0t: unexpected response, expected none, actual %p", $time, rsp);
			end else begin
				want = pending_rsp_q.pop_front();
				if (rsp.found !== want.found) begin
					n_err++;
					$display("%0t: found mismatch, expected %0b, actual %0b",
						$time, want.found, rsp.found);
				end
				if (rsp.slot_index !== want.slot_index) begin
					n_err++;
					$display("%0t: slot_index mismatch, expected %0d, actual %0d",
						$time, want.slot_index, rsp.slot_index);
				end
				if (rsp.is_new !== want.is_new) begin
					n_err++;
					$display("%0t: is_new mismatch, expected %0b, actual %0b",
						$time, want.is_new, rsp.is_new);
				end
				if (!want.found)
					n_miss_seen++;
				else if (want.is_new)
					n_alloc_seen++;
				else
					n_hit_seen++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d responses outstanding", $time,
				pending_rsp_q.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		req_valid    = 1'b0;
		req          = '0;
		n_err        = 0;
		n_sent       = 0;
		n_hit_seen   = 0;
		n_alloc_seen = 0;
		n_miss_seen  = 0;
		cycle_count  = 0;
		for (int i = 0; i < NSLOTS; i++) begin
			slot_addr_m[i] = bts_pkg::ADDR_RESET;
			slot_bank_m[i] = bts_pkg::BANK_RESET;
			slot_age_m[i]  = bts_pkg::AGE_RESET;
		end
		age_count_m = bts_pkg::COUNT_RESET;
		for (int i = 0; i < N_KEYS; i++) begin
			if (i % 3 == 0)
				key_addr[i] = bts_pkg::ADDR_W'($urandom_range(0, 16'h3FFF));
			else
				key_addr[i] = bts_pkg::ADDR_W'($urandom_range(16'h4000, 16'hFFFF));
			key_bank[i] = bts_pkg::BANK_W'($urandom_range(0, 511));
		end
		key_addr[0] = bts_pkg::ADDR_RESET;
		key_bank[0] = bts_pkg::BANK_RESET;

		dir_tab = '{
			'{'{bts_pkg::CMD_LOOKUP, 16'hFFFF, 9'h000}, 1'b1, '{1'b1, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_LOOKUP, 16'hFFFF, 9'h005}, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_LOOKUP, 16'h3FFF, 9'h1FF}, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_LOOKUP, 16'h0000, 9'h1FF}, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'h0000, 9'h1FF}, 1'b1, '{1'b1, 3'd0, 1'b1}},
			'{'{bts_pkg::CMD_LOOKUP, 16'h0000, 9'h0AA}, 1'b1, '{1'b1, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_LOOKUP, 16'hFFFF, 9'h000}, 1'b1, '{1'b1, 3'd1, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'hFFFF, 9'h1FF}, 1'b1, '{1'b1, 3'd1, 1'b1}},
			'{'{bts_pkg::CMD_ALLOC,  16'hFFFF, 9'h1FF}, 1'b1, '{1'b1, 3'd1, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'h4000, 9'h100}, 1'b1, '{1'b1, 3'd2, 1'b1}},
			'{'{bts_pkg::CMD_LOOKUP, 16'h4000, 9'h000}, 1'b1, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'h3FFF, 9'h1FF}, 1'b1, '{1'b1, 3'd3, 1'b1}},
			'{'{bts_pkg::CMD_ALLOC,  16'h8000, 9'h0F0}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'hC000, 9'h155}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'h7FFF, 9'h0AA}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'h1234, 9'h000}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'hABCD, 9'h1FF}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_LOOKUP, 16'h0000, 9'h000}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'hFFFF, 9'h000}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_LOOKUP, 16'hFFFF, 9'h1FF}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'h3FFF, 9'h0AA}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_LOOKUP, 16'h4000, 9'h100}, 1'b0, '{1'b0, 3'd0, 1'b0}},
			'{'{bts_pkg::CMD_ALLOC,  16'h0001, 9'h1FF}, 1'b0, '{1'b0, 3'd0, 1'b0}}
		};

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[i])
			send_request(dir_tab[i].stim, dir_tab[i].fixed, dir_tab[i].known);

		for (int k = 0; k < N_RANDOM; k++) begin
			if (k == 450) begin
				// drain the block before going on
				@(negedge clk);
				req_valid = 1'b0;
				wait (pending_rsp_q.size() == 0);
			end
			send_request(random_request(), 1'b0, '0);
		end
		@(negedge clk);
		req_valid = 1'b0;

		wait (pending_rsp_q.size() == 0);
		repeat (4 * (NSLOTS + 2)) @(posedge clk);
		if (pending_rsp_q.size() != 0) begin
			n_err++;
			$display("%0t: %0d responses never arrived, expected next %p", $time,
				pending_rsp_q.size(), pending_rsp_q[0]);
		end

		$display("run covered %0d requests: %0d hits, %0d allocations, %0d misses",
			n_sent, n_hit_seen, n_alloc_seen, n_miss_seen);
		$display("with random idling, one long output hold-off and one full drain");
		if (n_err == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/bts_pkg.sv
hw/rtl/bts_cell.sv
hw/rtl/bank_tag_slot_cache_unit.sv
bench/bank_tag_slot_cache_unit_test.sv
